// ----- src/bpc_pkg.sv -----
// Package for barometric pressure compensation: register indexes and shared widths.
// No dependencies.
`timescale 1ns / 1ps
package bpc_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AC123 = 3'd0,
    REG_AC456 = 3'd1,
    REG_B12   = 3'd2,
    REG_MCMD  = 3'd3,
    REG_OSS   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [18:0] raw_press;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temp_decidegree;
    logic signed [31:0] pressure_pa;
    logic               div_error;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;
endpackage

// ----- src/bpc_if.sv -----
// Valid/ready channel interfaces for the compensation block.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
interface bpc_in_if;
  logic               valid;
  logic               ready;
  bpc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  bpc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpc_cfg_if;
  logic               valid;
  logic               ready;
  bpc_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/bpc_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// No dependencies; bpc_pkg types are used only by the parent.
`timescale 1ns / 1ps
module bpc_div #(
  parameter int unsigned W = 32,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  input  logic [SW-1:0] side_i,
  output logic [W-1:0]  quo_o,
  output logic [SW-1:0] side_o
);
  // each stage: partial remainder, remaining dividend bits/quotient, divisor
  logic [W-1:0]  rem_q [1:W];
  logic [W-1:0]  nq_q  [1:W];
  logic [W-1:0]  den_q [1:W];
  logic [SW-1:0] sd_q  [1:W];

  for (genvar s = 0; s < W; s++) begin : g_st
    logic [W-1:0]  rem_c;
    logic [W-1:0]  nq_c;
    logic [W-1:0]  den_c;
    logic [SW-1:0] sd_c;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic [W-1:0]  rem_d;
    logic [W-1:0]  nq_d;
    if (s == 0) begin : g_first
      assign rem_c = '0;
      assign nq_c  = num_i;
      assign den_c = den_i;
      assign sd_c  = side_i;
    end else begin : g_next
      assign rem_c = rem_q[s];
      assign nq_c  = nq_q[s];
      assign den_c = den_q[s];
      assign sd_c  = sd_q[s];
    end
    always_comb begin
      trial = {rem_c, nq_c[W-1]};
      diff  = trial - {1'b0, den_c};
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        nq_d  = {nq_c[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        nq_d  = {nq_c[W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= rem_d;
        nq_q[s+1]  <= nq_d;
        den_q[s+1] <= den_c;
        sd_q[s+1]  <= sd_c;
      end
    end
  end

  assign quo_o  = nq_q[W];
  assign side_o = sd_q[W];
endmodule

// ----- src/barometric_pressure_compensation.sv -----
// Top level of the barometric pressure compensation pipeline.
// Depends on bpc_pkg, bpc_if and bpc_div.
//
//  channel  dir  transaction payload
//  in_ch    in   raw_temp[15:0], raw_press[18:0]
//  out_ch   out  temp_decidegree, pressure_pa (signed 32), div_error
//  cfg_ch   in   index[2:0], data[47:0]; always ready
//
// One item per cycle enters while the pipe advances; the result passes through
// two 32-stage dividers (temperature, then pressure) plus the other register
// stages S1 to S10 and the output register.
// The whole pipe advances only when its last stage is empty or being taken,
// so a stall freezes every stage; nothing is lost or repeated.
// Reset clears the valid bits and the calibration registers.
`timescale 1ns / 1ps
module barometric_pressure_compensation (
  input logic   clk_i,
  input logic   rst_ni,
  bpc_in_if.sink    in_ch,
  bpc_out_if.source out_ch,
  bpc_cfg_if.sink   cfg_ch
);
  import bpc_pkg::*;

  localparam int unsigned NV = 10; // valid bits for non-divider stages

  logic [47:0] a123_q, a456_q;
  logic [31:0] b12_q, mcmd_q;
  logic [1:0]  oss_q;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a123_q <= '0; a456_q <= '0; b12_q <= '0; mcmd_q <= '0; oss_q <= '0;
    end else if (cfg_ch.valid) begin
      case (reg_idx_e'(cfg_ch.data.index))
        REG_AC123: a123_q <= cfg_ch.data.data;
        REG_AC456: a456_q <= cfg_ch.data.data;
        REG_B12:   b12_q  <= cfg_ch.data.data[31:0];
        REG_MCMD:  mcmd_q <= cfg_ch.data.data[31:0];
        REG_OSS:   oss_q  <= cfg_ch.data.data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  always_comb begin
    ac1 = {{16{a123_q[47]}}, a123_q[47:32]};
    ac2 = {{16{a123_q[31]}}, a123_q[31:16]};
    ac3 = {{16{a123_q[15]}}, a123_q[15:0]};
    ac4 = {16'd0, a456_q[47:32]};
    ac5 = {16'd0, a456_q[31:16]};
    ac6 = {16'd0, a456_q[15:0]};
    b1  = {{16{b12_q[31]}}, b12_q[31:16]};
    b2  = {{16{b12_q[15]}}, b12_q[15:0]};
    mc  = {{16{mcmd_q[31]}}, mcmd_q[31:16]};
    md  = {{16{mcmd_q[15]}}, mcmd_q[15:0]};
  end

  // global advance: pipe moves when output slot is free or being taken
  logic adv;
  logic out_v_q;
  assign adv = !out_v_q || out_ch.ready;
  assign in_ch.ready = adv;

  // valid line across the whole pipe (divider stages included)
  localparam int unsigned DIVL = 32;
  localparam int unsigned TOT = NV + 2 * DIVL;
  logic [TOT-1:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[TOT-2:0], in_ch.valid};
  end

  // S1: x1 product
  logic [31:0] s1_prod_q, s1_up_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_prod_q <= ({16'd0, in_ch.data.raw_temp} - ac6) * ac5;
      s1_up_q   <= {13'd0, in_ch.data.raw_press};
    end
  end

  // S2: x1, divisor, signed operands to magnitude form
  logic [31:0] x1t, tden, tnum;
  always_comb begin
    x1t  = $signed(s1_prod_q) >>> 15;
    tden = x1t + md;
    tnum = mc << 11;
  end
  logic [31:0] s2_x1_q, s2_num_q, s2_den_q, s2_up_q;
  logic        s2_neg_q, s2_z_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_x1_q  <= x1t;
      s2_num_q <= tnum[31] ? -tnum : tnum;
      s2_den_q <= tden[31] ? -tden : tden;
      s2_neg_q <= tnum[31] ^ tden[31];
      s2_z_q   <= tden == 32'd0;
      s2_up_q  <= s1_up_q;
    end
  end

  // temperature divider; side band carries x1, up, sign, zero flag
  localparam int unsigned TSW = 66;
  logic [31:0] tq;
  logic [TSW-1:0] tside;
  bpc_div #(.W(32), .SW(TSW)) u_tdiv (
    .clk_i, .en_i(adv), .num_i(s2_num_q), .den_i(s2_den_q),
    .side_i({s2_x1_q, s2_up_q, s2_neg_q, s2_z_q}),
    .quo_o(tq), .side_o(tside)
  );

  // S3: b5, t, b6
  logic [31:0] x2t, b5;
  always_comb begin
    x2t = tside[0] ? 32'd0 : (tside[1] ? -tq : tq);
    b5  = tside[65:34] + x2t;
  end
  logic [31:0] s3_t_q, s3_b6_q, s3_up_q;
  logic        s3_err_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_t_q   <= $signed(b5 + 32'd8) >>> 4;
      s3_b6_q  <= b5 - 32'd4000;
      s3_up_q  <= tside[33:2];
      s3_err_q <= tside[0];
    end
  end

  // S4: b6 squared, ac2*b6, ac3*b6
  logic [31:0] s4_sq_q, s4_a2_q, s4_a3_q, s4_t_q, s4_up_q;
  logic        s4_err_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_sq_q  <= s3_b6_q * s3_b6_q;
      s4_a2_q  <= ac2 * s3_b6_q;
      s4_a3_q  <= ac3 * s3_b6_q;
      s4_t_q   <= s3_t_q;
      s4_up_q  <= s3_up_q;
      s4_err_q <= s3_err_q;
    end
  end

  // S5: b2*b6sq, b1*b6sq
  logic [31:0] b6sq;
  assign b6sq = $signed(s4_sq_q) >>> 12;
  logic [31:0] s5_p2_q, s5_p1_q, s5_a2_q, s5_a3_q, s5_t_q, s5_up_q;
  logic        s5_err_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_p2_q  <= b2 * b6sq;
      s5_p1_q  <= b1 * b6sq;
      s5_a2_q  <= s4_a2_q;
      s5_a3_q  <= s4_a3_q;
      s5_t_q   <= s4_t_q;
      s5_up_q  <= s4_up_q;
      s5_err_q <= s4_err_q;
    end
  end

  // S6: b3 and x3 for b4 (signed sums keep the shifts arithmetic)
  logic [31:0] x3a, b3, x3b, b3s;
  always_comb begin
    x3a = ($signed(s5_p2_q) >>> 11) + ($signed(s5_a2_q) >>> 11);
    b3s = ((ac1 << 2) + x3a) << oss_q;
    b3  = $signed(b3s + 32'd2) >>> 2;
    x3b = $signed(($signed(s5_a3_q) >>> 13) + ($signed(s5_p1_q) >>> 16) + 32'sd2) >>> 2;
  end
  logic [31:0] s6_upb_q, s6_x3_q, s6_t_q;
  logic        s6_err_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_upb_q <= s5_up_q - b3;
      s6_x3_q  <= x3b + 32'd32768;
      s6_t_q   <= s5_t_q;
      s6_err_q <= s5_err_q;
    end
  end

  // S7: b4 and b7 products
  logic [31:0] s7_b4p_q, s7_b7_q, s7_t_q;
  logic        s7_err_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_b4p_q <= ac4 * s6_x3_q;
      s7_b7_q  <= s6_upb_q * (32'd50000 >> oss_q);
      s7_t_q   <= s6_t_q;
      s7_err_q <= s6_err_q;
    end
  end

  // S8: divider operands; large b7 divides first then doubles
  logic [31:0] b4;
  assign b4 = s7_b4p_q >> 15;
  logic [31:0] s8_num_q, s8_den_q, s8_t_q;
  logic        s8_big_q, s8_z_q, s8_err_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_big_q <= s7_b7_q[31];
      s8_num_q <= s7_b7_q[31] ? s7_b7_q : (s7_b7_q << 1);
      s8_den_q <= b4;
      s8_z_q   <= b4 == 32'd0;
      s8_t_q   <= s7_t_q;
      s8_err_q <= s7_err_q;
    end
  end

  localparam int unsigned PSW = 35;
  logic [31:0] pq;
  logic [PSW-1:0] pside;
  bpc_div #(.W(32), .SW(PSW)) u_pdiv (
    .clk_i, .en_i(adv), .num_i(s8_num_q), .den_i(s8_den_q),
    .side_i({s8_t_q, s8_big_q, s8_z_q, s8_err_q}),
    .quo_o(pq), .side_o(pside)
  );

  // S9: p and (p>>8)^2, -7357*p
  logic [31:0] p0, ps8;
  always_comb begin
    p0  = pside[1] ? 32'd0 : (pside[2] ? (pq << 1) : pq);
    ps8 = $signed(p0) >>> 8;
  end
  logic [31:0] s9_p_q, s9_sq_q, s9_m_q, s9_t_q;
  logic        s9_err_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_p_q   <= p0;
      s9_sq_q  <= ps8 * ps8;
      s9_m_q   <= p0 * 32'hFFFF_E343;
      s9_t_q   <= pside[34:3];
      s9_err_q <= pside[0] | pside[1];
    end
  end

  // S10: 3038 product
  logic [31:0] s10_p_q, s10_k_q, s10_m_q, s10_t_q;
  logic        s10_err_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s10_k_q   <= s9_sq_q * 32'd3038;
      s10_p_q   <= s9_p_q;
      s10_m_q   <= s9_m_q;
      s10_t_q   <= s9_t_q;
      s10_err_q <= s9_err_q;
    end
  end

  // output stage
  logic [31:0] corr;
  assign corr = $signed(($signed(s10_k_q) >>> 16) + ($signed(s10_m_q) >>> 16)
                + 32'sd3791) >>> 4;
  out_item_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= v_q[TOT-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.temp_decidegree <= s10_t_q;
      out_q.pressure_pa     <= s10_p_q + corr;
      out_q.div_error       <= s10_err_q;
    end
  end
  assign out_ch.valid = out_v_q;
  assign out_ch.data  = out_q;
endmodule
